### src/jsu_pkg.sv
// Shared types and constants for the JSON string unescape block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package jsu_pkg;

    localparam int LenW = 27;
    localparam logic [LenW-1:0] MaxLenReset = 27'h4000000;

    localparam int QAw = 2;
    localparam int QDepth = 1 << QAw;

    localparam int CmdBytes = 6;

    localparam logic [2:0] ST_DATA        = 3'd0;
    localparam logic [2:0] ST_END         = 3'd1;
    localparam logic [2:0] ST_UNCLOSED    = 3'd2;
    localparam logic [2:0] ST_ESC_CUT     = 3'd3;
    localparam logic [2:0] ST_SHORT_U     = 3'd4;
    localparam logic [2:0] ST_BAD_HEX     = 3'd5;
    localparam logic [2:0] ST_UNKNOWN_ESC = 3'd6;
    localparam logic [2:0] ST_TOO_LONG    = 3'd7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } t_out_item;

    // Work for the back end: n_data bytes, then an optional terminal status.
    typedef struct packed {
        logic [CmdBytes-1:0][7:0] data;
        logic [2:0]               n_data;
        logic [2:0]               term;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

### src/jsu_front.sv
// Front end: decodes one input item per cycle, while the queue is not full, into a byte/terminal command.
// Holds decode state and the length register; depends on jsu_pkg.
`default_nettype none

module jsu_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire jsu_pkg::t_in_item i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [26:0]       i_cfg_data,
    output logic                   o_wr,
    output jsu_pkg::t_cmd          o_cmd
);

    typedef enum logic [2:0] {
        M_PLAIN,
        M_ESC,
        M_HEX,
        M_HEXBAD,
        M_SUR_BS,
        M_SUR_U,
        M_SUR_HEX
    } t_mode;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_utf8;

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.b[0] = cp[7:0];
            r.len  = 3'd1;
        end else if (cp <= 21'h7FF) begin
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
            r.len  = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
            r.len  = 3'd3;
        end else begin
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
            r.len  = 3'd4;
        end
        return r;
    endfunction

    t_mode                      r_mode, n_mode;
    logic [1:0]                 r_hc, n_hc;
    logic [15:0]                r_acc, n_acc;
    logic [9:0]                 r_held, n_held;
    logic [jsu_pkg::LenW-1:0]   r_count, n_count;
    logic [jsu_pkg::LenW-1:0]   r_max_len;

    logic [7:0]  b;
    logic        hv_ok;
    logic [3:0]  hv;
    logic [15:0] acc_sh;
    logic        rel;
    logic        feed;
    t_mode       eff;
    logic        take;
    logic [15:0] take_cp;
    logic        s_emit;
    logic        s_raw;
    logic [20:0] s_cp;
    logic [2:0]  s_term;
    logic [27:0] room;
    t_utf8       rb, sb;
    logic [2:0]  need;
    jsu_pkg::t_cmd cmd;

    assign b = i_item.in_byte;
    // bit 27 set: count already above the limit
    assign room = {1'b0, r_max_len} - {1'b0, r_count};

    always_comb begin
        hv_ok = 1'b1;
        hv    = 4'd0;
        if (b >= "0" && b <= "9") begin
            hv = 4'(b - "0");
        end else if (b >= "a" && b <= "f") begin
            hv = 4'(b - "a" + 8'd10);
        end else if (b >= "A" && b <= "F") begin
            hv = 4'(b - "A" + 8'd10);
        end else begin
            hv_ok = 1'b0;
        end
    end

    assign acc_sh = {r_acc[11:0], hv};

    always_comb begin
        n_mode  = r_mode;
        n_hc    = r_hc;
        n_acc   = r_acc;
        n_held  = r_held;
        rel     = 1'b0;
        feed    = 1'b0;
        eff     = r_mode;
        take    = 1'b0;
        take_cp = acc_sh;
        s_emit  = 1'b0;
        s_raw   = 1'b0;
        s_cp    = 21'd0;
        s_term  = jsu_pkg::ST_DATA;

        if (i_item.text_end) begin
            unique case (r_mode)
                M_SUR_BS: begin
                    rel    = 1'b1;
                    s_term = jsu_pkg::ST_UNCLOSED;
                end
                M_SUR_U: begin
                    rel    = 1'b1;
                    s_term = jsu_pkg::ST_ESC_CUT;
                end
                M_SUR_HEX: begin
                    rel    = 1'b1;
                    s_term = jsu_pkg::ST_SHORT_U;
                end
                M_ESC:           s_term = jsu_pkg::ST_ESC_CUT;
                M_HEX, M_HEXBAD: s_term = jsu_pkg::ST_SHORT_U;
                default:         s_term = jsu_pkg::ST_UNCLOSED;
            endcase
        end else begin
            unique case (r_mode)
                M_SUR_BS: begin
                    if (b == "\\") begin
                        n_mode = M_SUR_U;
                    end else begin
                        rel  = 1'b1;
                        feed = 1'b1;
                        eff  = M_PLAIN;
                    end
                end
                M_SUR_U: begin
                    if (b == "u") begin
                        n_mode = M_SUR_HEX;
                        n_hc   = 2'd0;
                        n_acc  = 16'd0;
                    end else begin
                        rel  = 1'b1;
                        feed = 1'b1;
                        eff  = M_ESC;
                    end
                end
                M_SUR_HEX: begin
                    if (!hv_ok) begin
                        rel  = 1'b1;
                        feed = 1'b1;
                        eff  = M_HEX;
                    end else if (r_hc != 2'd3) begin
                        n_acc = acc_sh;
                        n_hc  = r_hc + 2'd1;
                    end else if (acc_sh[15:10] == 6'b110111) begin
                        s_emit = 1'b1;
                        s_cp   = 21'h10000 + {1'b0, r_held, acc_sh[9:0]};
                        n_mode = M_PLAIN;
                        n_hc   = 2'd0;
                        n_acc  = 16'd0;
                        n_held = 10'd0;
                    end else begin
                        rel  = 1'b1;
                        take = 1'b1;
                    end
                end
                default: feed = 1'b1;
            endcase

            if (rel) begin
                n_held = 10'd0;
            end

            if (feed) begin
                unique case (eff)
                    M_ESC: begin
                        n_mode = M_PLAIN;
                        s_emit = 1'b1;
                        case (b)
                            "\"", "\\", "/": s_cp = {13'd0, b};
                            "b": s_cp = 21'h08;
                            "f": s_cp = 21'h0C;
                            "n": s_cp = 21'h0A;
                            "r": s_cp = 21'h0D;
                            "t": s_cp = 21'h09;
                            "u": begin
                                s_emit = 1'b0;
                                n_mode = M_HEX;
                                n_hc   = 2'd0;
                                n_acc  = 16'd0;
                            end
                            default: begin
                                s_emit = 1'b0;
                                s_term = jsu_pkg::ST_UNKNOWN_ESC;
                            end
                        endcase
                    end
                    M_HEX: begin
                        if (!hv_ok) begin
                            if (r_hc == 2'd3) begin
                                s_term = jsu_pkg::ST_BAD_HEX;
                            end else begin
                                n_hc   = r_hc + 2'd1;
                                n_mode = M_HEXBAD;
                            end
                        end else begin
                            n_acc  = acc_sh;
                            n_mode = M_HEX;
                            if (r_hc == 2'd3) begin
                                take = 1'b1;
                            end else begin
                                n_hc = r_hc + 2'd1;
                            end
                        end
                    end
                    M_HEXBAD: begin
                        if (r_hc == 2'd3) begin
                            s_term = jsu_pkg::ST_BAD_HEX;
                        end else begin
                            n_hc = r_hc + 2'd1;
                        end
                    end
                    default: begin
                        n_mode = M_PLAIN;
                        if (b == "\"") begin
                            s_term = jsu_pkg::ST_END;
                        end else if (b == "\\") begin
                            n_mode = M_ESC;
                        end else begin
                            s_emit = 1'b1;
                            s_raw  = 1'b1;
                            s_cp   = {13'd0, b};
                        end
                    end
                endcase
            end

            if (take) begin
                n_hc  = 2'd0;
                n_acc = 16'd0;
                if (take_cp[15:10] == 6'b110110) begin
                    n_held = take_cp[9:0];
                    n_mode = M_SUR_BS;
                end else begin
                    n_mode = M_PLAIN;
                    s_emit = 1'b1;
                    s_cp   = {5'd0, take_cp};
                end
            end
        end
    end

    assign rb = utf8_enc({5'd0, 6'b110110, r_held});

    // body bytes pass through as they are, 0x80-0xFF included
    always_comb begin
        sb = utf8_enc(s_cp);
        if (s_raw) begin
            sb      = '0;
            sb.b[0] = b;
            sb.len  = 3'd1;
        end
    end

    always_comb begin
        cmd      = '0;
        cmd.term = s_term;
        need     = 3'd0;
        if (rel && (room[27] || room < 28'd3)) begin
            cmd.term = jsu_pkg::ST_TOO_LONG;
        end else begin
            if (rel) begin
                cmd.data[0]  = rb.b[0];
                cmd.data[1]  = rb.b[1];
                cmd.data[2]  = rb.b[2];
                cmd.n_data   = 3'd3;
            end
            if (s_emit) begin
                need = (rel ? 3'd3 : 3'd0) + sb.len;
                if (!room[27] && room >= {25'd0, need}) begin
                    if (rel) begin
                        cmd.data[3] = sb.b[0];
                        cmd.data[4] = sb.b[1];
                        cmd.data[5] = sb.b[2];
                    end else begin
                        cmd.data[0] = sb.b[0];
                        cmd.data[1] = sb.b[1];
                        cmd.data[2] = sb.b[2];
                        cmd.data[3] = sb.b[3];
                    end
                    cmd.n_data = need;
                end else begin
                    cmd.term = jsu_pkg::ST_TOO_LONG;
                end
            end
        end
        n_count = r_count + {24'd0, cmd.n_data};
    end

    assign o_cmd = cmd;
    assign o_wr  = i_take && (cmd.n_data != 3'd0 || cmd.term != jsu_pkg::ST_DATA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_PLAIN;
            r_hc      <= 2'd0;
            r_acc     <= 16'd0;
            r_held    <= 10'd0;
            r_count   <= '0;
            r_max_len <= jsu_pkg::MaxLenReset;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (i_take) begin
                if (cmd.term != jsu_pkg::ST_DATA) begin
                    r_mode  <= M_PLAIN;
                    r_hc    <= 2'd0;
                    r_acc   <= 16'd0;
                    r_held  <= 10'd0;
                    r_count <= '0;
                end else begin
                    r_mode  <= n_mode;
                    r_hc    <= n_hc;
                    r_acc   <= n_acc;
                    r_held  <= n_held;
                    r_count <= n_count;
                end
            end
        end
    end

endmodule

`default_nettype wire

### src/jsu_queue.sv
// Short command queue between front and back end, head shown ahead.
// Depends on jsu_pkg for the command type and depth.
`default_nettype none

module jsu_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire jsu_pkg::t_cmd  i_cmd,
    input  wire logic           i_rd,
    output jsu_pkg::t_cmd       o_head,
    output jsu_pkg::t_q_status  o_status
);

    jsu_pkg::t_cmd              r_mem [jsu_pkg::QDepth];
    logic [jsu_pkg::QAw-1:0]    r_wp, r_rp;
    logic [jsu_pkg::QAw:0]      r_cnt;
    logic                       wr_en, rd_en;

    assign o_status.full  = (r_cnt == (jsu_pkg::QAw+1)'(jsu_pkg::QDepth));
    assign o_status.empty = (r_cnt == '0);
    assign wr_en  = i_wr && !o_status.full;
    assign rd_en  = i_rd && !o_status.empty;
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/jsu_back.sv
// Back end: walks the head command into the output register, one result per cycle while it is empty or popped.
// Depends on jsu_pkg for the command and result types.
`default_nettype none

module jsu_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire jsu_pkg::t_cmd      i_head,
    input  wire jsu_pkg::t_q_status i_q,
    output logic                    o_head_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output jsu_pkg::t_out_item      o_out
);

    logic                  r_valid;
    jsu_pkg::t_out_item    r_out, n_out;
    logic [2:0]            r_idx;
    logic [2:0]            total;
    logic                  load;
    logic [7:0]            sel_byte;

    assign total = i_head.n_data + {2'd0, i_head.term != jsu_pkg::ST_DATA};
    assign load  = !i_q.empty && (!r_valid || i_pop);

    always_comb begin
        case (r_idx)
            3'd0:    sel_byte = i_head.data[0];
            3'd1:    sel_byte = i_head.data[1];
            3'd2:    sel_byte = i_head.data[2];
            3'd3:    sel_byte = i_head.data[3];
            3'd4:    sel_byte = i_head.data[4];
            3'd5:    sel_byte = i_head.data[5];
            default: sel_byte = 8'd0;
        endcase
        if (r_idx < i_head.n_data) begin
            n_out.out_byte = sel_byte;
            n_out.status   = jsu_pkg::ST_DATA;
        end else begin
            n_out.out_byte = 8'd0;
            n_out.status   = i_head.term;
        end
        n_out.last = (r_idx + 3'd1 == total);
    end

    assign o_head_pop = load && n_out.last;
    assign o_empty    = !r_valid;
    assign o_out      = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_out.last ? 3'd0 : r_idx + 3'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### src/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescape to UTF-8 block.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
// Channel   Direction  Handshake                 Payload
// input     in         push / full               i_in  (t_in_item)
// result    out        empty / pop               o_out (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (max_length)
//
// The front end takes one item per cycle while full is low; results go out one
// per cycle while pop is held. Input rate is set by the back end; the four-entry
// command queue absorbs bursts before full rises. Synchronous reset clears the
// decode state and the queue and empties the output register;
// max_length resets to 2^26. o_cfg_ready is always high.
`default_nettype none

module json_string_unescape_utf8_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire jsu_pkg::t_in_item  i_in,
    output logic                    empty,
    input  wire logic               pop,
    output jsu_pkg::t_out_item      o_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [26:0]        i_cfg_data
);

    logic               take;
    logic               wr;
    jsu_pkg::t_cmd      cmd;
    jsu_pkg::t_cmd      head;
    jsu_pkg::t_q_status q_st;
    logic               head_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = q_st.full;
    assign take        = push && !q_st.full;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (i_in),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_wr       (wr),
        .o_cmd      (cmd)
    );

    jsu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_cmd    (cmd),
        .i_rd     (head_pop),
        .o_head   (head),
        .o_status (q_st)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q        (q_st),
        .o_head_pop (head_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

### src/jsu_checker.sv
// Port-level checks for the JSON string unescape block, bound to the top level.
// Depends on jsu_pkg for the result type and status codes.
`default_nettype none

module jsu_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire jsu_pkg::t_out_item o_out
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not cleared by reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out))
        else $error("stalled result changed");

    a_term_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out.status != jsu_pkg::ST_DATA |-> o_out.out_byte == 8'd0)
        else $error("terminal result carries a byte");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out.status != jsu_pkg::ST_DATA |-> o_out.last)
        else $error("terminal result not last of its item");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

`default_nettype wire

### sim/jsu_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the JSON string unescape testbench: decodes accepted input items
// into the results the block must produce and checks them in order. Depends on jsu_pkg.
package jsu_tb_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [2:0] {
        DM_PLAIN, DM_ESC, DM_HEX, DM_HEXBAD, DM_SUR_BS, DM_SUR_U, DM_SUR_HEX
    } t_decode_mode;

    class jsu_scoreboard;
        jsu_pkg::t_out_item decoded_q[$];
        jsu_pkg::t_out_item step_q[$];
        t_decode_mode mode;
        logic [1:0]   hex_cnt;
        logic [15:0]  acc;
        logic [15:0]  held;
        int unsigned  out_len;
        int unsigned  max_len;
        int           errors;

        function new();
            max_len = jsu_pkg::MaxLenReset;
            errors  = 0;
            restart();
        endfunction

        function void restart();
            mode    = DM_PLAIN;
            hex_cnt = 2'd0;
            acc     = 16'h0;
            held    = 16'h0;
            out_len = 0;
        endfunction

        function void set_max_len(logic [26:0] v);
            max_len = v;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void put(logic [7:0] b, logic [2:0] st);
            jsu_pkg::t_out_item r;
            if (step_q.size() >= 7) return;
            r.out_byte = b;
            r.status   = st;
            r.last     = 1'b0;
            step_q = {step_q, r};
        endfunction

        function void close_string(logic [2:0] st);
            put(8'h00, st);
            restart();
        endfunction

        function bit emit_raw(logic [7:0] b);
            if (out_len + 1 > max_len) begin
                close_string(jsu_pkg::ST_TOO_LONG);
                return 1'b0;
            end
            put(b, jsu_pkg::ST_DATA);
            out_len += 1;
            return 1'b1;
        endfunction

        function bit emit_code(logic [20:0] cp);
            logic [7:0] b [4];
            int n;
            if (cp <= 21'h7F) return emit_raw(cp[7:0]);
            if (cp <= 21'h7FF) begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
                n = 2;
            end else if (cp <= 21'hFFFF) begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
                n = 3;
            end else begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
                n = 4;
            end
            if (out_len + n > max_len) begin
                close_string(jsu_pkg::ST_TOO_LONG);
                return 1'b0;
            end
            for (int i = 0; i < n; i++) put(b[i], jsu_pkg::ST_DATA);
            out_len += n;
            return 1'b1;
        endfunction

        function int hex_value(logic [7:0] h);
            if (h >= 8'h30 && h <= 8'h39) return h - 8'h30;
            if (h >= 8'h61 && h <= 8'h66) return h - 8'h61 + 10;
            if (h >= 8'h41 && h <= 8'h46) return h - 8'h41 + 10;
            return -1;
        endfunction

        function void take_code(logic [15:0] cp);
            hex_cnt = 2'd0;
            acc     = 16'h0;
            if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                held = cp;
                mode = DM_SUR_BS;
                return;
            end
            mode = DM_PLAIN;
            void'(emit_code({5'd0, cp}));
        endfunction

        function bit release_high();
            logic [15:0] h;
            h    = held;
            held = 16'h0;
            return emit_code({5'd0, h});
        endfunction

        // A released high surrogate re-enters the byte in another mode.
        function void decode_byte(logic [7:0] b);
            bit          again;
            bit          known;
            int          v;
            logic [7:0]  eb;
            logic [15:0] cp;
            int unsigned pair;
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                case (mode)
                    DM_ESC: begin
                        known = 1'b1;
                        eb = b;
                        case (b)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: eb = b;
                            8'h62: eb = 8'h08;
                            8'h66: eb = 8'h0C;
                            8'h6E: eb = 8'h0A;
                            8'h72: eb = 8'h0D;
                            8'h74: eb = 8'h09;
                            default: known = 1'b0;
                        endcase
                        if (b == CH_U) begin
                            mode    = DM_HEX;
                            hex_cnt = 2'd0;
                            acc     = 16'h0;
                        end else if (known) begin
                            mode = DM_PLAIN;
                            void'(emit_raw(eb));
                        end else begin
                            close_string(jsu_pkg::ST_UNKNOWN_ESC);
                        end
                    end
                    DM_HEX: begin
                        v = hex_value(b);
                        if (v < 0) begin
                            if (hex_cnt == 2'd3) close_string(jsu_pkg::ST_BAD_HEX);
                            else begin
                                hex_cnt++;
                                mode = DM_HEXBAD;
                            end
                        end else begin
                            acc = {acc[11:0], v[3:0]};
                            if (hex_cnt == 2'd3) take_code(acc);
                            else hex_cnt++;
                        end
                    end
                    DM_HEXBAD: begin
                        if (hex_cnt == 2'd3) close_string(jsu_pkg::ST_BAD_HEX);
                        else hex_cnt++;
                    end
                    DM_SUR_BS: begin
                        if (b == CH_BSLASH) mode = DM_SUR_U;
                        else if (release_high()) begin
                            mode  = DM_PLAIN;
                            again = 1'b1;
                        end
                    end
                    DM_SUR_U: begin
                        if (b == CH_U) begin
                            mode    = DM_SUR_HEX;
                            hex_cnt = 2'd0;
                            acc     = 16'h0;
                        end else if (release_high()) begin
                            mode  = DM_ESC;
                            again = 1'b1;
                        end
                    end
                    DM_SUR_HEX: begin
                        v = hex_value(b);
                        if (v < 0) begin
                            if (release_high()) begin
                                mode  = DM_HEX;
                                again = 1'b1;
                            end
                        end else begin
                            acc = {acc[11:0], v[3:0]};
                            if (hex_cnt != 2'd3) hex_cnt++;
                            else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                                pair = 'h10000 + ((held - 'hD800) << 10) + (acc - 'hDC00);
                                mode    = DM_PLAIN;
                                hex_cnt = 2'd0;
                                acc     = 16'h0;
                                held    = 16'h0;
                                void'(emit_code(pair[20:0]));
                            end else begin
                                cp = acc;
                                if (release_high()) take_code(cp);
                            end
                        end
                    end
                    default: begin
                        mode = DM_PLAIN;
                        if (b == CH_QUOTE) close_string(jsu_pkg::ST_END);
                        else if (b == CH_BSLASH) mode = DM_ESC;
                        else void'(emit_raw(b));
                    end
                endcase
            end
        endfunction

        function void end_of_text();
            case (mode)
                DM_ESC:            close_string(jsu_pkg::ST_ESC_CUT);
                DM_HEX, DM_HEXBAD: close_string(jsu_pkg::ST_SHORT_U);
                DM_SUR_BS:  if (release_high()) close_string(jsu_pkg::ST_UNCLOSED);
                DM_SUR_U:   if (release_high()) close_string(jsu_pkg::ST_ESC_CUT);
                DM_SUR_HEX: if (release_high()) close_string(jsu_pkg::ST_SHORT_U);
                default:           close_string(jsu_pkg::ST_UNCLOSED);
            endcase
        endfunction

        function void note_input(jsu_pkg::t_in_item it);
            step_q.delete();
            if (it.text_end) end_of_text();
            else decode_byte(it.in_byte);
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i]) decoded_q = {decoded_q, step_q[i]};
        endfunction

        function void check_result(jsu_pkg::t_out_item got);
            jsu_pkg::t_out_item want;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: expected no result, got %02h st %0d last %0d",
                         $time, got.out_byte, got.status, got.last);
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte || got.status !== want.status ||
                got.last !== want.last) begin
                errors++;
                $display("%0t: expected %02h st %0d last %0d, got %02h st %0d last %0d",
                         $time, want.out_byte, want.status, want.last,
                         got.out_byte, got.status, got.last);
            end
        endfunction
    endclass
endpackage

### sim/json_string_unescape_utf8_top_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for json_string_unescape_utf8_top: random JSON string bodies
// with random push/pop idling and length-limit changes. Depends on jsu_pkg and jsu_tb_pkg.
module json_string_unescape_utf8_top_tb;

    localparam int CycleLimit  = 300000;
    localparam int DrainCycles = 24;
    localparam logic [63:0] EscChars = {jsu_tb_pkg::CH_QUOTE, jsu_tb_pkg::CH_BSLASH,
                                        jsu_tb_pkg::CH_SLASH, "bfnrt"};

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic               pop         = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [26:0]        i_cfg_data  = '0;
    jsu_pkg::t_in_item  i_in        = '0;
    logic               full;
    logic               empty;
    logic               o_cfg_ready;
    jsu_pkg::t_out_item o_out;

    jsu_tb_pkg::jsu_scoreboard sb = new();
    bit            steady_send = 1'b0;
    bit            steady_take = 1'b0;
    int            items_sent  = 0;
    int unsigned   cycles      = 0;

    json_string_unescape_utf8_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66));
        return c;
    endfunction

    // 0 ascii, 1 two-byte, 2 three-byte, 3 high surrogate, 4 low surrogate
    function automatic logic [15:0] pick_code(int kind);
        case (kind)
            0: return 16'($urandom_range(0, 'h7F));
            1: return 16'($urandom_range('h80, 'h7FF));
            2: return $urandom_range(0, 1) ? 16'($urandom_range('h800, 'hD7FF))
                                           : 16'($urandom_range('hE000, 'hFFFF));
            3: return 16'($urandom_range('hD800, 'hDBFF));
            default: return 16'($urandom_range('hDC00, 'hDFFF));
        endcase
    endfunction

    task automatic send_item(logic [7:0] b, logic te);
        int gap;
        jsu_pkg::t_in_item it;
        gap = steady_send ? 0 : $urandom_range(0, 5);
        it.in_byte  = b;
        it.text_end = te;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_u(logic [15:0] v);
        send_byte(jsu_tb_pkg::CH_BSLASH);
        send_byte(jsu_tb_pkg::CH_U);
        for (int i = 3; i >= 0; i--) send_byte(hex_char(v[4*i +: 4]));
    endtask

    task automatic send_high_tail();
        int n;
        logic [15:0] lo;
        send_u(pick_code(3));
        case ($urandom_range(0, 6))
            0: send_u(pick_code(4));
            1: send_u(pick_code($urandom_range(0, 2)));
            2: send_u(pick_code(3));
            3: send_byte(8'($urandom_range(0, 255)));
            4: begin
                send_byte(jsu_tb_pkg::CH_BSLASH);
                send_byte(8'($urandom_range(0, 255)));
            end
            5: begin
                n = $urandom_range(0, 3);
                send_byte(jsu_tb_pkg::CH_BSLASH);
                send_byte(jsu_tb_pkg::CH_U);
                repeat (n) send_byte(hex_char(4'($urandom_range(0, 15))));
                send_byte(non_hex());
            end
            default: begin
                // text ends part way into the following \u
                n  = $urandom_range(0, 5);
                lo = pick_code(4);
                for (int i = 0; i < n; i++) begin
                    if (i == 0) send_byte(jsu_tb_pkg::CH_BSLASH);
                    else if (i == 1) send_byte(jsu_tb_pkg::CH_U);
                    else send_byte(hex_char(lo[15 - 4*(i-2) -: 4]));
                end
                send_end();
            end
        endcase
    endtask

    task automatic send_broken();
        int pos;
        case ($urandom_range(0, 4))
            0: begin
                send_byte(jsu_tb_pkg::CH_BSLASH);
                send_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                pos = $urandom_range(0, 3);
                send_byte(jsu_tb_pkg::CH_BSLASH);
                send_byte(jsu_tb_pkg::CH_U);
                for (int i = 0; i < 4; i++)
                    send_byte(i == pos ? non_hex() : hex_char(4'($urandom_range(0, 15))));
            end
            2: begin
                send_byte(jsu_tb_pkg::CH_BSLASH);
                send_byte(jsu_tb_pkg::CH_U);
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 3) == 0) send_byte(non_hex());
                    else send_byte(hex_char(4'($urandom_range(0, 15))));
                end
                send_end();
            end
            3: begin
                send_byte(jsu_tb_pkg::CH_BSLASH);
                send_end();
            end
            default: send_end();
        endcase
    endtask

    task automatic send_string();
        int kind;
        int k;
        steady_send = ($urandom_range(0, 7) == 0);
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(0, 19);
            if (kind < 7) send_byte(8'($urandom_range(0, 255)));
            else if (kind < 10) begin
                send_byte(jsu_tb_pkg::CH_BSLASH);
                send_byte(EscChars[8*$urandom_range(0, 7) +: 8]);
            end
            else if (kind < 13) send_u(pick_code($urandom_range(0, 4)));
            else if (kind < 16) begin
                send_u(pick_code(3));
                send_u(pick_code(4));
            end
            else if (kind < 18) send_high_tail();
            else send_broken();
        end
        k = $urandom_range(0, 9);
        if (k < 7) send_byte(jsu_tb_pkg::CH_QUOTE);
        else if (k < 9) send_end();
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_max_len(logic [26:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_max_len(v);
    endtask

    initial begin
        int n;
        while (!i_rst_n) @(posedge i_clk);
        n = 0;
        forever begin
            if (n % 64 == 0) steady_take = ($urandom_range(0, 3) == 0);
            n++;
            if (!steady_take && $urandom_range(0, 5) > 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_out);
        end
    end

    initial begin
        logic [26:0] len;
        int target;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("\\uD83D\\uDE00\"");
        send_text("\\q");
        send_text("\\u12G4");
        send_item(8'hFF, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: len = 27'd1;
                1: len = jsu_pkg::MaxLenReset;
                2: len = 27'($urandom_range(2, 12));
                default: len = 27'($urandom_range(13, 200));
            endcase
            wait_idle();
            write_max_len(len);
            target = items_sent + (ph == 0 ? 60 : 110);
            while (items_sent < target) send_string();
        end
        steady_send = 1'b0;
        wait_idle();

        if (sb.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

### filelist.f
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8_top.sv
src/jsu_checker.sv
sim/jsu_tb_pkg.sv
sim/json_string_unescape_utf8_top_tb.sv
